// File: sv/assert_macros.svh
// Shared assertion macros for the ring replica selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: sv/rrlls_pkg.sv
package rrlls_pkg;

	// Default ring size and alive-map row geometry
	localparam int NODE_COUNT_DEF = 256;
	localparam int ROW_W = 32;
	localparam int ROW_B = 5;

	// Reset value of the port base register
	localparam logic [15:0] PORT_BASE_RST = 16'd40000;

	// Input word kinds
	localparam logic REQ_PLACE  = 1'b0;
	localparam logic REQ_STATUS = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [30:0] requester_id;
		logic [7:0]  node_id;
		logic        node_alive;
	} req_t;

	typedef struct packed {
		logic [30:0] client_echo;
		logic [15:0] first_port;
		logic [15:0] second_port;
		logic [15:0] third_port;
		logic        none_alive;
	} rsp_t;

	// Index of the lowest set bit of a row (zero when the row is empty)
	function automatic logic [ROW_B-1:0] first_set(input logic [ROW_W-1:0] row);
		logic [ROW_B-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (row[i]) begin
				idx = ROW_B'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: sv/rrlls_ram.sv
module rrlls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/rrlls_mod.sv
module rrlls_mod import rrlls_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [30:0]                   cid,
	output logic                          done,
	output logic [$clog2(NODE_COUNT)-1:0] rem
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int SHIFT = 31 + IDX_W;
	// Reciprocal of the ring size, rounded up; exact for every 31-bit dividend
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT);

	logic [30:0]      x_q;
	logic [62:0]      prod_q;
	logic [IDX_W-1:0] rem_q;
	logic             run_q;
	logic             mul_q;
	logic             done_q;
	logic [30:0]      quot;
	logic [30:0]      back;
	logic [30:0]      diff;

	// Take the quotient out of the product and subtract it back from the dividend
	always_comb begin
		quot = 31'(prod_q >> SHIFT);
		back = quot * 31'(NODE_COUNT);
		diff = x_q - back;
	end

	// Advance the sequence: load, multiply, subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			mul_q  <= run_q;
			done_q <= mul_q;
		end
	end

	// Hold the dividend, the product and the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= cid;
		end
		if (run_q) begin
			prod_q <= 63'(x_q) * 63'(RECIP[31:0]);
		end
		if (mul_q) begin
			rem_q <= diff[IDX_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: sv/ring_replica_least_load_select.sv
// Replica placement over a ring of NODE_COUNT storage nodes. A status word
// (start high while busy is low) sets one node's alive bit; a node_id at or
// beyond NODE_COUNT is dropped. A placement word walks the ring from
// requester_id mod NODE_COUNT for three alive nodes, bumps the load of the
// least-loaded one, moves it to the front and reports port_base plus each
// node index; if no node is alive it reports none_alive with zero ports.
// Each result is shown for one cycle with done high and cannot be held off,
// so the receiver must take it then. A status word reads its alive-map row
// and writes it back with the node's bit set to node_alive; one whose
// node_id is dropped leaves the block idle. A placement word runs the
// reciprocal modulo unit, then reads the alive map one 32-node row at a
// time during the three ring walks (a walk that finds no alive node ends
// the placement with none_alive), then reads three loads from the load
// memory, which has one read and one write port, and writes one back.
// After reset the block clears both memories with busy high. port_base
// is taken over the cfg channel, which is always ready; write it while the
// block is idle so a placement in progress keeps one base.
module ring_replica_least_load_select import rrlls_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  req_t        request,
	output logic        busy,
	output logic        done,
	output rsp_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int ROWS   = (NODE_COUNT + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int POS_W  = ROW_AW + ROW_B;
	localparam int VIS_W  = $clog2(ROWS + 1);
	localparam int TAIL   = NODE_COUNT % ROW_W;
	localparam logic [ROW_W-1:0] LAST_MASK =
		(TAIL == 0) ? {ROW_W{1'b1}} : ROW_W'((64'd1 << TAIL) - 64'd1);

	typedef enum logic [7:0] {
		S_CLEAR   = 8'b0000_0001,
		S_IDLE    = 8'b0000_0010,
		S_STAT_RD = 8'b0000_0100,
		S_STAT_WR = 8'b0000_1000,
		S_MOD     = 8'b0001_0000,
		S_SEEK    = 8'b0010_0000,
		S_LOAD    = 8'b0100_0000,
		S_WRITE   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [15:0]       port_base_q;
	req_t              req_q;
	logic [ROW_AW-1:0] row_q;
	logic [ROW_B-1:0]  off_q;
	logic              first_q;
	logic [VIS_W-1:0]  vis_q;
	logic [1:0]        npick_q;
	logic [POS_W-1:0]  pick0_q;
	logic [POS_W-1:0]  pick1_q;
	logic [POS_W-1:0]  pick2_q;
	logic [1:0]        ldcnt_q;
	logic [7:0]        ld0_q;
	logic [7:0]        ld1_q;
	logic              done_q;
	rsp_t              result_q;

	logic              accept;
	logic              mod_start;
	logic              mod_done;
	logic [IDX_W-1:0]  mod_rem;

	logic              a_we;
	logic [ROW_AW-1:0] a_waddr;
	logic [ROW_W-1:0]  a_wdata;
	logic [ROW_AW-1:0] a_raddr;
	logic [ROW_W-1:0]  a_rdata;

	logic              l_we;
	logic [IDX_W-1:0]  l_waddr;
	logic [7:0]        l_wdata;
	logic [IDX_W-1:0]  l_raddr;
	logic [7:0]        l_rdata;

	logic [ROW_AW-1:0] stat_row;
	logic [ROW_AW-1:0] clr_row;
	logic [POS_W-1:0]  mod_pos;
	logic [ROW_W-1:0]  masked;
	logic              hit_any;
	logic [POS_W-1:0]  hit;
	logic [POS_W:0]    hit_inc;
	logic [POS_W-1:0]  start_nxt;
	logic [ROW_AW-1:0] miss_row;
	logic              search_dead;

	logic [7:0]        lb01;
	logic [7:0]        lbest;
	logic [1:0]        best;
	logic [POS_W-1:0]  sel0;
	logic [POS_W-1:0]  sel1;
	logic [POS_W-1:0]  sel2;

	assign accept    = start && !busy;
	assign mod_start = accept && (request.req_type == REQ_PLACE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	rrlls_mod #(
		.NODE_COUNT(NODE_COUNT)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.cid   (request.requester_id),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	// Alive map: one 32-node row per entry
	rrlls_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_alive (
		.clk  (clk),
		.we   (a_we),
		.waddr(a_waddr),
		.wdata(a_wdata),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	// Load counts: one node per entry
	rrlls_ram #(
		.WIDTH(8),
		.DEPTH(NODE_COUNT)
	) u_load (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	// Find the next alive node in the row just read
	always_comb begin
		stat_row    = ROW_AW'(req_q.node_id >> ROW_B);
		clr_row     = ROW_AW'(clr_q);
		mod_pos     = POS_W'(mod_rem);
		masked      = a_rdata & (first_q ? ({ROW_W{1'b1}} << off_q) : {ROW_W{1'b1}});
		hit_any     = |masked;
		hit         = {row_q, first_set(masked)};
		hit_inc     = {1'b0, hit} + 1'b1;
		start_nxt   = (hit_inc == (POS_W+1)'(NODE_COUNT)) ? '0 : hit_inc[POS_W-1:0];
		miss_row    = (row_q == ROW_AW'(ROWS - 1)) ? '0 : row_q + 1'b1;
		search_dead = !hit_any && (vis_q == VIS_W'(ROWS));
	end

	// Pick the least-loaded of the three, earliest on ties, and swap it forward
	always_comb begin
		lb01  = (ld0_q > ld1_q) ? ld1_q : ld0_q;
		best  = (ld0_q > ld1_q) ? 2'd1 : 2'd0;
		lbest = lb01;
		if (lb01 > l_rdata) begin
			best  = 2'd2;
			lbest = l_rdata;
		end
		case (best)
			2'd1: begin
				sel0 = pick1_q;
				sel1 = pick0_q;
				sel2 = pick2_q;
			end
			2'd2: begin
				sel0 = pick2_q;
				sel1 = pick1_q;
				sel2 = pick0_q;
			end
			default: begin
				sel0 = pick0_q;
				sel1 = pick1_q;
				sel2 = pick2_q;
			end
		endcase
	end

	// Drive the memory ports from the current state
	always_comb begin
		a_we    = 1'b0;
		a_waddr = clr_row;
		a_wdata = (clr_row == ROW_AW'(ROWS - 1)) ? LAST_MASK : {ROW_W{1'b1}};
		a_raddr = row_q;
		l_we    = 1'b0;
		l_waddr = clr_q;
		l_wdata = '0;
		l_raddr = IDX_W'(pick0_q);
		case (state_q)
			S_CLEAR: begin
				a_we = (int'(clr_q) < ROWS);
				l_we = 1'b1;
			end
			S_STAT_RD: begin
				a_raddr = stat_row;
			end
			S_STAT_WR: begin
				a_we    = 1'b1;
				a_waddr = stat_row;
				a_wdata = a_rdata;
				a_wdata[req_q.node_id[ROW_B-1:0]] = req_q.node_alive;
			end
			S_MOD: begin
				a_raddr = mod_pos[POS_W-1:ROW_B];
			end
			S_SEEK: begin
				a_raddr = hit_any ? start_nxt[POS_W-1:ROW_B] : miss_row;
			end
			S_LOAD: begin
				case (ldcnt_q)
					2'd0:    l_raddr = IDX_W'(pick0_q);
					2'd1:    l_raddr = IDX_W'(pick1_q);
					default: l_raddr = IDX_W'(pick2_q);
				endcase
			end
			S_WRITE: begin
				l_we    = 1'b1;
				l_waddr = IDX_W'(sel0);
				l_wdata = lbest + 8'd1;
			end
			default: begin
				a_we = 1'b0;
			end
		endcase
	end

	// Sequence clearing, status updates and placement searches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			port_base_q <= PORT_BASE_RST;
			done_q      <= 1'b0;
			npick_q     <= '0;
			ldcnt_q     <= '0;
			vis_q       <= '0;
			first_q     <= 1'b0;
			row_q       <= '0;
			off_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				port_base_q <= cfg_data;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (request.req_type == REQ_PLACE) begin
							state_q <= S_MOD;
						end else if (int'(request.node_id) < NODE_COUNT) begin
							state_q <= S_STAT_RD;
						end
					end
				end
				S_STAT_RD: begin
					state_q <= S_STAT_WR;
				end
				S_STAT_WR: begin
					state_q <= S_IDLE;
				end
				S_MOD: begin
					if (mod_done) begin
						row_q   <= mod_pos[POS_W-1:ROW_B];
						off_q   <= mod_pos[ROW_B-1:0];
						first_q <= 1'b1;
						vis_q   <= '0;
						npick_q <= '0;
						state_q <= S_SEEK;
					end
				end
				S_SEEK: begin
					if (hit_any) begin
						row_q   <= start_nxt[POS_W-1:ROW_B];
						off_q   <= start_nxt[ROW_B-1:0];
						first_q <= 1'b1;
						vis_q   <= '0;
						npick_q <= npick_q + 1'b1;
						if (npick_q == 2'd2) begin
							ldcnt_q <= '0;
							state_q <= S_LOAD;
						end
					end else if (search_dead) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						row_q   <= miss_row;
						first_q <= 1'b0;
						vis_q   <= vis_q + 1'b1;
					end
				end
				S_LOAD: begin
					ldcnt_q <= ldcnt_q + 1'b1;
					if (ldcnt_q == 2'd2) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted word, found nodes, loads and the outgoing result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (state_q == S_SEEK && hit_any) begin
			case (npick_q)
				2'd0:    pick0_q <= hit;
				2'd1:    pick1_q <= hit;
				default: pick2_q <= hit;
			endcase
		end
		if (state_q == S_LOAD && ldcnt_q == 2'd1) begin
			ld0_q <= l_rdata;
		end
		if (state_q == S_LOAD && ldcnt_q == 2'd2) begin
			ld1_q <= l_rdata;
		end
		if (state_q == S_SEEK && search_dead) begin
			result_q.client_echo <= req_q.requester_id;
			result_q.first_port  <= '0;
			result_q.second_port <= '0;
			result_q.third_port  <= '0;
			result_q.none_alive  <= 1'b1;
		end
		if (state_q == S_WRITE) begin
			result_q.client_echo <= req_q.requester_id;
			result_q.first_port  <= port_base_q + 16'(sel0);
			result_q.second_port <= port_base_q + 16'(sel1);
			result_q.third_port  <= port_base_q + 16'(sel2);
			result_q.none_alive  <= 1'b0;
		end
	end

endmodule

// File: sv/rrlls_chk.sv
`include "assert_macros.svh"

module rrlls_chk import rrlls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic done,
	input rsp_t result
);

	// A result only leaves once the block has gone back to idle
	`ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)

	// With no alive node all ports are zero
	`ASSERT_IMP(a_dead_zero, clk, arst_n, done && result.none_alive, (result.first_port == 16'd0) && (result.second_port == 16'd0) && (result.third_port == 16'd0))

	// A placement word keeps the block busy after it is taken
	`ASSERT_NXT(a_place_busy, clk, arst_n, start && !busy && (request.req_type == REQ_PLACE), busy && !done)

	// A status word never yields a result
	`ASSERT_NXT(a_stat_quiet, clk, arst_n, start && !busy && (request.req_type == REQ_STATUS), !done)

endmodule

bind ring_replica_least_load_select rrlls_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.request(request),
	.done   (done),
	.result (result)
);

// File: sim/ring_replica_least_load_select_tb.sv
`timescale 1ns / 1ps

module ring_replica_least_load_select_tb;
	import rrlls_pkg::*;

	localparam int RING = NODE_COUNT_DEF;

	// Track ring state and the placements still due from the block
	class placement_board;
		bit        up_map [RING];
		bit [7:0]  load_map [RING];
		bit [15:0] port_base;
		rsp_t      placements_due [$];
		int        errors;

		function new();
			foreach (up_map[n]) begin
				up_map[n] = 1'b1;
				load_map[n] = '0;
			end
			port_base = PORT_BASE_RST;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// Walk the ring from a position to the first node that is up
		function bit next_up(int from, output int hit);
			int pos;
			hit = 0;
			for (int n = 0; n < RING; n++) begin
				pos = (from + n) % RING;
				if (up_map[pos]) begin
					hit = pos;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Apply one accepted word and queue the placement it produces
		function void note_word(req_t w);
			int   pick [3];
			int   lead;
			int   held;
			rsp_t due;
			if (w.req_type == REQ_STATUS) begin
				if (int'(w.node_id) < RING) begin
					up_map[w.node_id] = w.node_alive;
				end
				return;
			end
			due = '0;
			due.client_echo = w.requester_id;
			if (!next_up(int'(w.requester_id % RING), pick[0])) begin
				due.none_alive = 1'b1;
			end else begin
				void'(next_up(pick[0] + 1, pick[1]));
				void'(next_up(pick[1] + 1, pick[2]));
				// Strictly lower load wins, so ties stay with the earliest node
				lead = 0;
				for (int k = 1; k < 3; k++) begin
					if (load_map[pick[lead]] > load_map[pick[k]]) begin
						lead = k;
					end
				end
				load_map[pick[lead]]++;
				held = pick[lead];
				pick[lead] = pick[0];
				pick[0] = held;
				due.first_port = port_base + 16'(pick[0]);
				due.second_port = port_base + 16'(pick[1]);
				due.third_port = port_base + 16'(pick[2]);
			end
			placements_due = {placements_due, due};
		endfunction

		// Compare a strobed result word with the oldest placement due
		function void check_word(rsp_t got);
			rsp_t want;
			if (placements_due.size() == 0) begin
				flag($sformatf("unexpected result: echo %0d ports %0d %0d %0d none %0b",
					got.client_echo, got.first_port, got.second_port, got.third_port,
					got.none_alive));
				return;
			end
			want = placements_due.pop_front();
			if (got.client_echo !== want.client_echo || got.first_port !== want.first_port ||
					got.second_port !== want.second_port ||
					got.third_port !== want.third_port || got.none_alive !== want.none_alive) begin
				flag({$sformatf("mismatch: expected echo %0d ports %0d %0d %0d none %0b\n",
					want.client_echo, want.first_port, want.second_port, want.third_port,
					want.none_alive),
					$sformatf("          got      echo %0d ports %0d %0d %0d none %0b",
					got.client_echo, got.first_port, got.second_port, got.third_port,
					got.none_alive)});
			end
		endfunction

		function void close_out();
			if (placements_due.size() > 0) begin
				flag($sformatf("%0d placements never returned", placements_due.size()));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	req_t        request;
	logic        busy;
	logic        done;
	rsp_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	placement_board board;
	bit             burst;

	ring_replica_least_load_select #(
		.NODE_COUNT(RING)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Check every result word on its strobe
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			board.check_word(result);
		end
	end

	// Placement word with noise in the status-only fields
	function automatic req_t place_word(logic [30:0] cid);
		req_t w;
		w.req_type = REQ_PLACE;
		w.requester_id = cid;
		w.node_id = 8'($urandom);
		w.node_alive = 1'($urandom);
		return w;
	endfunction

	// Status word with noise in the requester field
	function automatic req_t status_word(int node, logic up);
		req_t w;
		w.req_type = REQ_STATUS;
		w.requester_id = 31'($urandom);
		w.node_id = 8'(node);
		w.node_alive = up;
		return w;
	endfunction

	// Hold start until the block takes the word, idling first at random
	task automatic send(req_t w);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			burst = !burst;
		end
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= w;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		board.note_word(w);
	endtask

	// Drop start and wait until every placement is back and status words are done
	task automatic settle();
		start <= 1'b0;
		while (board.placements_due.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_base(logic [15:0] base);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= base;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		board.port_base = base;
	endtask

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [15:0] bases [5];
		int          lone;
		int          waited;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		burst = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ring wrap, ties, dead start nodes, port wrap
		send(place_word(31'd0));
		send(place_word(31'd0));
		send(place_word(31'h7FFF_FFFF));
		send(place_word(31'd255));
		send(status_word(0, 1'b0));
		send(status_word(255, 1'b0));
		send(status_word(1, 1'b1));
		send(place_word(31'd255));
		send(place_word(31'd256));
		send(status_word(255, 1'b1));
		send(status_word(0, 1'b1));
		send(place_word(31'd254));
		write_base(16'hFFFF);
		send(place_word(31'd255));
		send(place_word(31'd1));
		write_base(16'd65280);
		send(place_word(31'h7FFF_FF00));
		write_base(16'd0);
		send(place_word(31'h4000_0003));

		bases[0] = 16'hFFFF;
		bases[1] = 16'd0;
		bases[2] = 16'd65280;
		bases[3] = 16'($urandom);
		bases[4] = PORT_BASE_RST;

		// Random phases, each under its own port base
		for (int ph = 0; ph < 5; ph++) begin
			write_base(bases[ph]);
			if (ph == 1 || ph == 4) begin
				// Take most of the ring down, then place among the survivors
				for (int n = 0; n < RING; n++) begin
					send(status_word(n, $urandom_range(0, 29) == 0));
				end
				repeat (120) begin
					if ($urandom_range(0, 19) < 17) begin
						send(place_word(31'($urandom)));
					end else begin
						send(status_word($urandom_range(0, RING - 1),
							$urandom_range(0, 4) == 0));
					end
				end
			end else if (ph == 2) begin
				// One node up long enough for its load to wrap, then none, then two
				lone = $urandom_range(0, RING - 1);
				for (int n = 0; n < RING; n++) begin
					if (board.up_map[n]) begin
						send(status_word(n, 1'b0));
					end
				end
				send(status_word(lone, 1'b1));
				repeat (270) send(place_word(31'($urandom)));
				send(status_word(lone, 1'b0));
				repeat (6) send(place_word(31'($urandom)));
				send(status_word(lone, 1'b1));
				send(status_word($urandom_range(0, RING - 1), 1'b1));
				repeat (10) send(place_word(31'($urandom)));
			end else begin
				// Bring most of the ring back up before mixed traffic
				if (ph == 3) begin
					for (int n = 0; n < RING; n++) begin
						send(status_word(n, $urandom_range(0, 9) != 0));
					end
				end
				repeat (150) begin
					if ($urandom_range(0, 9) < 7) begin
						send(place_word(31'($urandom)));
					end else begin
						send(status_word($urandom_range(0, RING - 1),
							$urandom_range(0, 3) != 0));
					end
				end
			end
		end

		// Drain outstanding placements with a bound, then let the block go quiet
		start <= 1'b0;
		waited = 0;
		while (board.placements_due.size() > 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		board.close_out();
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
